@@ hw/rtl/ordered_list_append_delete_dump_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Ordered list unit: assertion macros
// Shared property forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_DELETE_DUMP_UNIT_DEFINES_SVH
`define ORDERED_LIST_APPEND_DELETE_DUMP_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define OLAD_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define OLAD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/olad_pkg.sv @@
// ----------------------------------------------------------------------------
// olad_pkg
// Types, codes and defaults shared by the ordered list unit.
// ----------------------------------------------------------------------------
package olad_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VALUE_W      = 32;

	// operation codes on the input tuser
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_LIST   = 2'd2;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_LISTED    = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_APPLY,
		S_LIST
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_APPEND,
		OP_DELETE,
		OP_ROTATE
	} dp_op_t;

	typedef enum logic [1:0] {
		VSEL_VALUE,
		VSEL_HEAD,
		VSEL_ZERO
	} val_sel_t;

	typedef struct packed {
		logic     capture;
		logic     search;
		dp_op_t   op;
		logic     load_out;
		status_t  out_status;
		val_sel_t val_sel;
		logic     out_last;
		logic     list_start;
		logic     list_step;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       is_empty;
		logic       is_full;
		logic       found;
		logic       one_entry;
		logic       list_last;
	} dp_status_t;

endpackage

@@ hw/rtl/ordered_list_append_delete_dump_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_append_delete_dump_unit
// Bounded insertion-ordered list of signed 32-bit values with append,
// delete-first-match and listing.
// ----------------------------------------------------------------------------
// Append and delete step through capture, compare of all cells, and update with
// the load of the result word; a listing steps through capture and compare, then
// gives one result word per stored entry (one ST_EMPTY word if empty), as the
// cell chain rotates by one position per result. Unused kind codes are taken and
// dropped without a result. The next word is accepted as soon as the last result
// of the current one is in the output register, so a stalled output holds one
// result while the next operation runs up to its own result.
module ordered_list_append_delete_dump_unit import olad_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [1:0]  s_tuser,  // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [2:0] status, [34:3] item_value, [39:35] zero
	output logic        m_tlast
);

	dp_cmd_t            cmd;
	dp_status_t         st;
	status_t            out_status;
	logic [VALUE_W-1:0] out_value;

	olad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_kind  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	olad_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_value   (s_tdata),
		.in_kind    (s_tuser),
		.cmd        (cmd),
		.st         (st),
		.out_status (out_status),
		.out_value  (out_value),
		.out_last   (m_tlast)
	);

	assign m_tdata = {5'd0, out_value, out_status};

endmodule

@@ hw/rtl/olad_ctrl.sv @@
// ----------------------------------------------------------------------------
// olad_ctrl
// Sequencer for the ordered list: input handshake, operation steps and
// output word valid.
// ----------------------------------------------------------------------------
module olad_ctrl import olad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] in_kind,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	logic   kind_ok;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign kind_ok  = (in_kind == KIND_APPEND) || (in_kind == KIND_DELETE) ||
		(in_kind == KIND_LIST);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && kind_ok)
					state_nx = S_SEARCH;
			end
			S_SEARCH: state_nx = S_APPLY;
			S_APPLY: begin
				if (out_free) begin
					if (st.kind == KIND_LIST && !st.is_empty && !st.one_entry)
						state_nx = S_LIST;
					else
						state_nx = S_IDLE;
				end
			end
			S_LIST: begin
				if (out_free && st.list_last)
					state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.op         = OP_NONE;
		cmd.out_status = ST_INSERTED;
		cmd.val_sel    = VSEL_VALUE;
		unique case (state_q)
			S_IDLE: cmd.capture = accept;
			S_SEARCH: cmd.search = 1'b1;
			S_APPLY: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_last = 1'b1;
					unique case (st.kind)
						KIND_APPEND: begin
							if (st.is_full) begin
								cmd.out_status = ST_FULL;
							end else begin
								cmd.op         = OP_APPEND;
								cmd.out_status = ST_INSERTED;
							end
						end
						KIND_DELETE: begin
							if (st.is_empty) begin
								cmd.out_status = ST_EMPTY;
							end else if (!st.found) begin
								cmd.out_status = ST_NOT_FOUND;
							end else begin
								cmd.op         = OP_DELETE;
								cmd.out_status = ST_DELETED;
							end
						end
						KIND_LIST: begin
							if (st.is_empty) begin
								cmd.out_status = ST_EMPTY;
								cmd.val_sel    = VSEL_ZERO;
							end else begin
								cmd.op         = OP_ROTATE;
								cmd.out_status = ST_LISTED;
								cmd.val_sel    = VSEL_HEAD;
								cmd.out_last   = st.one_entry;
								cmd.list_start = 1'b1;
							end
						end
						default: cmd.load_out = 1'b0;
					endcase
				end
			end
			S_LIST: begin
				if (out_free) begin
					cmd.load_out   = 1'b1;
					cmd.op         = OP_ROTATE;
					cmd.out_status = ST_LISTED;
					cmd.val_sel    = VSEL_HEAD;
					cmd.out_last   = st.list_last;
					cmd.list_step  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/olad_dp.sv @@
// ----------------------------------------------------------------------------
// olad_dp
// Entry cell chain with parallel compare, gap-closing shift, rotation for
// listing, entry count and the output word register.
// ----------------------------------------------------------------------------
module olad_dp import olad_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] in_value,
	input  logic [1:0]         in_kind,
	input  dp_cmd_t            cmd,
	output dp_status_t         st,
	output status_t            out_status,
	output logic [VALUE_W-1:0] out_value,
	output logic               out_last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [VALUE_W-1:0] entries_q [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [1:0]         kind_q;
	logic [VALUE_W-1:0] value_q;
	logic [CAPACITY-1:0] match_q;
	logic [CAPACITY-1:0] from_first;
	logic [VALUE_W-1:0] out_value_nx;

	// ones from the first match up to the tail end of the chain
	assign from_first = ~((match_q & (~match_q + CAPACITY'(1))) - CAPACITY'(1));

	assign st.kind      = kind_q;
	assign st.is_empty  = (count_q == '0);
	assign st.is_full   = (count_q == CNT_W'(CAPACITY));
	assign st.found     = |match_q;
	assign st.one_entry = (count_q == CNT_W'(1));
	assign st.list_last = (idx_q + CNT_W'(1) == count_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= in_kind;
			value_q <= in_value;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.search)
				match_q[i] <= (CNT_W'(i) < count_q) && (entries_q[i] == value_q);
		end

		if (i < CAPACITY - 1) begin : g_mid
			always_ff @(posedge clk) begin
				unique case (cmd.op)
					OP_APPEND: begin
						if (CNT_W'(i) == count_q)
							entries_q[i] <= value_q;
					end
					OP_DELETE: begin
						if (from_first[i])
							entries_q[i] <= entries_q[i+1];
					end
					OP_ROTATE: begin
						// the entry at the tail wraps around to the head value
						if (CNT_W'(i) + CNT_W'(1) == count_q)
							entries_q[i] <= entries_q[0];
						else
							entries_q[i] <= entries_q[i+1];
					end
					default: ;
				endcase
			end
		end else begin : g_end
			always_ff @(posedge clk) begin
				unique case (cmd.op)
					OP_APPEND: begin
						if (CNT_W'(i) == count_q)
							entries_q[i] <= value_q;
					end
					OP_ROTATE: entries_q[i] <= entries_q[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.op == OP_APPEND)
				count_q <= count_q + CNT_W'(1);
			else if (cmd.op == OP_DELETE)
				count_q <= count_q - CNT_W'(1);
			if (cmd.list_start)
				idx_q <= CNT_W'(1);
			else if (cmd.list_step)
				idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_comb begin
		unique case (cmd.val_sel)
			VSEL_VALUE: out_value_nx = value_q;
			VSEL_HEAD:  out_value_nx = entries_q[0];
			VSEL_ZERO:  out_value_nx = '0;
			default:    out_value_nx = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status <= cmd.out_status;
			out_value  <= out_value_nx;
			out_last   <= cmd.out_last;
		end
	end

endmodule

@@ hw/rtl/olad_chk.sv @@
// ----------------------------------------------------------------------------
// olad_chk
// Port-level checks for the ordered list unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_list_append_delete_dump_unit_defines.svh"

module olad_chk import olad_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	`OLAD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
	`OLAD_ASSERT_SAME(a_status_code, clk, arst_n, m_tvalid, m_tdata[2:0] <= ST_FULL, "undefined status code")
	`OLAD_ASSERT_SAME(a_single_last, clk, arst_n, m_tvalid && m_tdata[2:0] != ST_LISTED, m_tlast, "non-listing result without tlast")
	`OLAD_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready && (s_tuser == KIND_APPEND || s_tuser == KIND_DELETE || s_tuser == KIND_LIST), !s_tready, "word taken while an operation is in flight")

endmodule

bind ordered_list_append_delete_dump_unit olad_chk u_olad_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
